// ===== rtl/wpv_pkg.sv =====
package wpv_pkg;

  // Square root of the squared distance: one result bit per cell
  localparam int ROOT_STEPS = 25;
  // Long division for the distance factor: one quotient bit per cell
  localparam int DIV_STEPS = 16;

  localparam logic [2:0] REG_REACH_TOL  = 3'd0;
  localparam logic [2:0] REG_TURN_GAIN  = 3'd1;
  localparam logic [2:0] REG_TURN_LIMIT = 3'd2;
  localparam logic [2:0] REG_SLOW_RAD   = 3'd3;
  localparam logic [2:0] REG_CRUISE     = 3'd4;

  localparam logic signed [26:0] VEC_HALF_TURN = 27'sd11796480;   // 180 deg in 2^-16 deg
  localparam logic [16:0] FULL_TURN_X2 = 17'd46080;
  localparam logic [16:0] FULL_TURN    = 17'd23040;
  localparam logic signed [17:0] FULL_TURN_S = 18'sd23040;
  localparam logic signed [17:0] HALF_TURN_S = 18'sd11520;
  localparam logic [13:0] QUARTER_TURN = 14'd5760;
  localparam logic signed [19:0] ROT_START = 20'sd39797;
  localparam logic [16:0] HF_ONE = 17'd65536;

  // Item as it travels down the chain; each stage fills in its own part
  typedef struct packed {
    logic               valid;
    logic [15:0]        idx;
    logic               inv;
    logic               last;
    logic               reach;
    logic               fin;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [15:0] hd;
    logic [49:0]        m1;
    logic [49:0]        m2;
    logic [49:0]        tolsq;
    logic [49:0]        rv;
    logic [49:0]        rr;
    logic signed [27:0] vx;
    logic signed [27:0] vy;
    logic signed [26:0] vz;
    logic signed [17:0] e;
    logic signed [32:0] tprod;
    logic               hen;
    logic signed [19:0] hx;
    logic signed [19:0] hy;
    logic signed [25:0] hz;
    logic               dsat;
    logic [23:0]        drem;
    logic [15:0]        q;
    logic [32:0]        p1;
    logic [16:0]        df;
    logic [15:0]        speed;
    logic signed [16:0] turn;
  } item_t;

  // atan(2^-i) in 2^-16 degree, rounded to nearest
  function automatic logic signed [26:0] atan_at(input int i);
    logic signed [26:0] v;
    v = '0;
    unique case (i)
      0:  v = 27'sd2949120;
      1:  v = 27'sd1740967;
      2:  v = 27'sd919879;
      3:  v = 27'sd466945;
      4:  v = 27'sd234379;
      5:  v = 27'sd117304;
      6:  v = 27'sd58666;
      7:  v = 27'sd29335;
      8:  v = 27'sd14668;
      9:  v = 27'sd7334;
      10: v = 27'sd3667;
      11: v = 27'sd1833;
      12: v = 27'sd917;
      13: v = 27'sd458;
      14: v = 27'sd229;
      15: v = 27'sd115;
      16: v = 27'sd57;
      17: v = 27'sd29;
      18: v = 27'sd14;
      19: v = 27'sd7;
      20: v = 27'sd4;
      21: v = 27'sd2;
      22: v = 27'sd1;
      default: v = 27'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/wpv_root_cell.sv =====
module wpv_root_cell #(
  parameter int STEP = 0,
  parameter int CORDIC_STEPS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  wpv_pkg::item_t d,
  output wpv_pkg::item_t q
);

  localparam logic [49:0] BIT = 50'(1) << (48 - 2 * STEP);

  wpv_pkg::item_t     nxt;
  logic [49:0]        trial;
  logic signed [27:0] xs;
  logic signed [27:0] ys;

  // One square root bit, and one vectoring rotation while STEP is below CORDIC_STEPS
  always_comb begin
    nxt   = d;
    trial = d.rr + BIT;
    xs    = d.vx >>> STEP;
    ys    = d.vy >>> STEP;
    if (d.rv >= trial) begin
      nxt.rv = d.rv - trial;
      nxt.rr = (d.rr >> 1) + BIT;
    end else begin
      nxt.rr = d.rr >> 1;
    end
    if (STEP < CORDIC_STEPS) begin
      if (d.vy > 0) begin
        nxt.vx = d.vx + ys;
        nxt.vy = d.vy - xs;
        nxt.vz = d.vz + wpv_pkg::atan_at(STEP);
      end else begin
        nxt.vx = d.vx - ys;
        nxt.vy = d.vy + xs;
        nxt.vz = d.vz - wpv_pkg::atan_at(STEP);
      end
    end
  end

  // Hand the item to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (adv) begin
      q <= nxt;
    end
  end

endmodule

// ===== rtl/wpv_rot_cell.sv =====
module wpv_rot_cell #(
  parameter int STEP = 0,
  parameter int CORDIC_STEPS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic [22:0]    radius,
  input  wpv_pkg::item_t d,
  output wpv_pkg::item_t q
);

  wpv_pkg::item_t     nxt;
  logic signed [19:0] xs;
  logic signed [19:0] ys;
  logic [24:0]        dbl;
  logic signed [25:0] ang;

  // One cosine rotation while STEP is below CORDIC_STEPS, one quotient bit while below DIV_STEPS
  always_comb begin
    nxt = d;
    xs  = d.hx >>> STEP;
    ys  = d.hy >>> STEP;
    ang = 26'(wpv_pkg::atan_at(STEP));
    dbl = {d.drem, 1'b0};
    if (STEP < CORDIC_STEPS) begin
      if (d.hz >= 0) begin
        nxt.hx = d.hx - ys;
        nxt.hy = d.hy + xs;
        nxt.hz = d.hz - ang;
      end else begin
        nxt.hx = d.hx + ys;
        nxt.hy = d.hy - xs;
        nxt.hz = d.hz + ang;
      end
    end
    if (STEP < wpv_pkg::DIV_STEPS) begin
      if (dbl >= {2'b0, radius}) begin
        nxt.drem = 24'(dbl - {2'b0, radius});
        nxt.q    = {d.q[14:0], 1'b1};
      end else begin
        nxt.drem = dbl[23:0];
        nxt.q    = {d.q[14:0], 1'b0};
      end
    end
  end

  // Hand the item to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (adv) begin
      q <= nxt;
    end
  end

endmodule

// ===== rtl/waypoint_pursuit_velocity_unit.sv =====
// Go-to-goal velocity unit: takes one pose/waypoint item per cycle unless a result waits
// at the output, and returns one command item per item.
// The chain holds two rows of cells: 25 square-root cells that run the bearing
// vectoring alongside, then max(16, CORDIC_STEPS) cells that run the cosine rotation
// alongside the 16-bit distance-factor division. The whole chain holds while a result
// waits at the output, so s_tready drops only while m_tvalid is high and m_tready low.
// Registers sit on the APB port at byte addresses 0x00 (reach tolerance), 0x04 (turn
// gain), 0x08 (turn rate limit), 0x0C (slow radius), 0x10 (cruise speed).
module waypoint_pursuit_velocity_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pose_x, pose_y, pose_heading, goal_x, goal_y, goal_index, goal_count
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // index_echo, speed_out, turn_out, zero fill
  output logic [55:0]  m_tdata,
  // reached
  output logic         m_tuser,
  output logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int ROT_CELLS = (CORDIC_STEPS > wpv_pkg::DIV_STEPS) ? CORDIC_STEPS
                                                                : wpv_pkg::DIV_STEPS;

  logic [22:0] reach_tol;
  logic [15:0] turn_gain;
  logic [15:0] turn_limit;
  logic [22:0] slow_radius;
  logic [15:0] cruise_speed;
  logic [2:0]  reg_sel;
  logic        adv;

  wpv_pkg::item_t s0, s1, s2, s3, s4, s5, s6, s7;
  wpv_pkg::item_t s0_next, s1_next, s2_next, s3_next, s4_next, s5_next, s6_next, s7_next;
  wpv_pkg::item_t ra [0:wpv_pkg::ROOT_STEPS];
  wpv_pkg::item_t rb [0:ROT_CELLS];

  logic [15:0]        in_idx, in_cnt;
  logic signed [23:0] in_px, in_py, in_gx, in_gy;
  logic signed [26:0] zr;
  logic signed [16:0] ang;
  logic [16:0]        ea;
  logic signed [17:0] er;
  logic [13:0]        eabs;
  logic [24:0]        root_dist;
  logic signed [32:0] tq;
  logic signed [32:0] lim;
  logic [16:0]        hf;
  logic [49:0]        p2;

  assign reg_sel = paddr[4:2];
  assign pready  = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      reach_tol    <= 23'd256;
      turn_gain    <= 16'd256;
      turn_limit   <= 16'd11520;
      slow_radius  <= 23'd2560;
      cruise_speed <= 16'd256;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        wpv_pkg::REG_REACH_TOL:  reach_tol    <= pwdata[22:0];
        wpv_pkg::REG_TURN_GAIN:  turn_gain    <= pwdata[15:0];
        wpv_pkg::REG_TURN_LIMIT: turn_limit   <= pwdata[15:0];
        wpv_pkg::REG_SLOW_RAD:   slow_radius  <= pwdata[22:0];
        wpv_pkg::REG_CRUISE:     cruise_speed <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_sel)
      wpv_pkg::REG_REACH_TOL:  prdata = {9'b0, reach_tol};
      wpv_pkg::REG_TURN_GAIN:  prdata = {16'b0, turn_gain};
      wpv_pkg::REG_TURN_LIMIT: prdata = {16'b0, turn_limit};
      wpv_pkg::REG_SLOW_RAD:   prdata = {9'b0, slow_radius};
      wpv_pkg::REG_CRUISE:     prdata = {16'b0, cruise_speed};
      default:                 prdata = 32'b0;
    endcase
  end

  // Hold the whole chain while a result waits
  assign adv      = !(s7.valid && !m_tready);
  assign s_tready = adv;

  assign in_px  = s_tdata[23:0];
  assign in_py  = s_tdata[47:24];
  assign in_gx  = s_tdata[87:64];
  assign in_gy  = s_tdata[111:88];
  assign in_idx = s_tdata[127:112];
  assign in_cnt = s_tdata[143:128];

  // Differences and index checks
  always_comb begin
    s0_next       = s0;
    s0_next.valid = s_tvalid;
    s0_next.idx   = in_idx;
    s0_next.inv   = (in_cnt == 16'd0) || (in_idx >= in_cnt);
    s0_next.last  = ({1'b0, in_idx} + 17'd1) >= {1'b0, in_cnt};
    s0_next.dx    = 25'(in_gx) - 25'(in_px);
    s0_next.dy    = 25'(in_gy) - 25'(in_py);
    s0_next.hd    = s_tdata[63:48];
  end

  // Squares
  always_comb begin
    s1_next       = s0;
    s1_next.m1    = 50'(s0.dx * s0.dx);
    s1_next.m2    = 50'(s0.dy * s0.dy);
    s1_next.tolsq = 50'(reach_tol * reach_tol);
  end

  // Reach test, root and vectoring start
  always_comb begin
    s2_next       = s1;
    s2_next.rv    = s1.m1 + s1.m2;
    s2_next.rr    = '0;
    s2_next.reach = !s1.inv && (s2_next.rv <= s1.tolsq);
    s2_next.fin   = s1.inv || (s2_next.reach && s1.last);
    if (s1.dy < 0) begin
      s2_next.vx = -28'(s1.dy);
      s2_next.vy = -28'(s1.dx);
      s2_next.vz = (s1.dx >= 0) ? wpv_pkg::VEC_HALF_TURN : -wpv_pkg::VEC_HALF_TURN;
    end else begin
      s2_next.vx = 28'(s1.dy);
      s2_next.vy = 28'(s1.dx);
      s2_next.vz = '0;
    end
  end

  assign ra[0] = s2;

  for (genvar i = 0; i < wpv_pkg::ROOT_STEPS; i++) begin : g_root
    wpv_root_cell #(.STEP(i), .CORDIC_STEPS(CORDIC_STEPS)) u_cell (
      .clk(clk), .rst(rst), .adv(adv), .d(ra[i]), .q(ra[i+1])
    );
  end

  // Round the bearing, subtract heading
  always_comb begin
    s3_next   = ra[wpv_pkg::ROOT_STEPS];
    zr        = ra[wpv_pkg::ROOT_STEPS].vz + 27'sd512;
    ang       = 17'(zr >>> 10);
    s3_next.e = 18'(ang) - 18'(ra[wpv_pkg::ROOT_STEPS].hd);
  end

  // Truncating remainder by a full turn, then wrap into the half-open range
  always_comb begin
    s4_next = s3;
    ea      = (s3.e < 0) ? 17'(-s3.e) : 17'(s3.e);
    if (ea >= wpv_pkg::FULL_TURN_X2) begin
      ea = ea - wpv_pkg::FULL_TURN_X2;
    end else if (ea >= wpv_pkg::FULL_TURN) begin
      ea = ea - wpv_pkg::FULL_TURN;
    end
    er = (s3.e < 0) ? -$signed({1'b0, ea}) : $signed({1'b0, ea});
    if (er > wpv_pkg::HALF_TURN_S) begin
      er = er - wpv_pkg::FULL_TURN_S;
    end
    if (er <= -wpv_pkg::HALF_TURN_S) begin
      er = er + wpv_pkg::FULL_TURN_S;
    end
    s4_next.e = er;
  end

  // Gain product, cosine and divider start
  always_comb begin
    s5_next       = s4;
    s5_next.tprod = 33'(s4.e * $signed({1'b0, turn_gain}));
    eabs          = (s4.e < 0) ? 14'(-s4.e) : 14'(s4.e);
    s5_next.hen   = eabs < wpv_pkg::QUARTER_TURN;
    s5_next.hx    = wpv_pkg::ROT_START;
    s5_next.hy    = '0;
    s5_next.hz    = $signed({2'b0, eabs, 10'b0});
    root_dist     = s4.rr[24:0];
    s5_next.dsat  = (slow_radius == 23'd0) || (root_dist >= {2'b0, slow_radius});
    s5_next.drem  = s5_next.dsat ? 24'd0 : 24'(root_dist);
    s5_next.q     = '0;
  end

  assign rb[0] = s5;

  for (genvar j = 0; j < ROT_CELLS; j++) begin : g_rot
    wpv_rot_cell #(.STEP(j), .CORDIC_STEPS(CORDIC_STEPS)) u_cell (
      .clk(clk), .rst(rst), .adv(adv), .radius(slow_radius), .d(rb[j]), .q(rb[j+1])
    );
  end

  // Turn clamp, factors, first speed product
  always_comb begin
    s6_next = rb[ROT_CELLS];
    tq      = (rb[ROT_CELLS].tprod + 33'sd128) >>> 8;
    lim     = $signed({17'b0, turn_limit});
    if (tq > lim) begin
      tq = lim;
    end else if (tq < -lim) begin
      tq = -lim;
    end
    s6_next.turn = (rb[ROT_CELLS].inv || rb[ROT_CELLS].reach) ? 17'sd0 : 17'(tq);
    if (!rb[ROT_CELLS].hen || rb[ROT_CELLS].hx < 0) begin
      hf = '0;
    end else if (rb[ROT_CELLS].hx > $signed({3'b0, wpv_pkg::HF_ONE})) begin
      hf = wpv_pkg::HF_ONE;
    end else begin
      hf = 17'(rb[ROT_CELLS].hx);
    end
    s6_next.df = rb[ROT_CELLS].dsat ? wpv_pkg::HF_ONE : {1'b0, rb[ROT_CELLS].q};
    s6_next.p1 = 33'(cruise_speed) * 33'(hf);
  end

  // Second speed product
  always_comb begin
    s7_next       = s6;
    p2            = 50'(s6.p1) * 50'(s6.df);
    s7_next.speed = (s6.inv || s6.reach) ? 16'd0 : p2[47:32];
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
      s4.valid <= 1'b0;
      s5.valid <= 1'b0;
      s6.valid <= 1'b0;
      s7.valid <= 1'b0;
    end else if (adv) begin
      s0 <= s0_next;
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
      s4 <= s4_next;
      s5 <= s5_next;
      s6 <= s6_next;
      s7 <= s7_next;
    end
  end

  assign m_tvalid = s7.valid;
  assign m_tdata  = {7'b0, s7.turn, s7.speed, s7.idx};
  assign m_tuser  = s7.reach;
  assign m_tlast  = s7.fin;

  // Reached or finished items carry no motion
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser || m_tlast) |-> m_tdata[48:16] == 33'b0)
    else $error("motion command on reached or finished item");

  // Input side stalls only behind a waiting result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == !(m_tvalid && !m_tready))
    else $error("input ready does not follow output stall");

  // Reset empties the chain
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule
